@@ src/pebr_pkg.sv @@
// Shared types and constants for the base relocation fixup block.
package pebr_pkg;

    localparam int ENTRY_W   = 16;
    localparam int ADDR_W    = 32;
    localparam int VALUE_W   = 64;
    localparam int WSIZE_W   = 2;
    localparam int STATUS_W  = 2;
    localparam int HALF_W    = 16;
    localparam int OFFSET_W  = 12;
    localparam int DELTA_W   = 32;

    localparam int S_TDATA_W = ((ENTRY_W + ADDR_W + VALUE_W + 7) / 8) * 8;
    localparam int M_FIELD_W = ADDR_W + VALUE_W + WSIZE_W + STATUS_W;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

    // m_tdata field positions
    localparam int M_VALUE_LSB  = ADDR_W;
    localparam int M_WSIZE_LSB  = ADDR_W + VALUE_W;
    localparam int M_STATUS_LSB = ADDR_W + VALUE_W + WSIZE_W;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [ADDR_W-1:0] ROUND_HALF = 32'h0000_8000;

    // relocation types
    localparam logic [3:0] TY_ABSOLUTE     = 4'd0;
    localparam logic [3:0] TY_HIGH         = 4'd1;
    localparam logic [3:0] TY_LOW          = 4'd2;
    localparam logic [3:0] TY_HIGHLOW      = 4'd3;
    localparam logic [3:0] TY_HIGHADJ      = 4'd4;
    localparam logic [3:0] TY_MIPS_JMPADDR = 4'd5;
    localparam logic [3:0] TY_DIR64        = 4'd10;

    // write sizes
    localparam logic [WSIZE_W-1:0] WS_NONE = 2'd0;
    localparam logic [WSIZE_W-1:0] WS_16   = 2'd1;
    localparam logic [WSIZE_W-1:0] WS_32   = 2'd2;
    localparam logic [WSIZE_W-1:0] WS_64   = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] ST_WAIT        = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNSUPPORTED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ADJ_MISSING = 2'd3;

    // how the back end forms the value from operand + delta
    typedef enum logic [2:0] {
        OP_ZERO,
        OP_HI16,
        OP_LO16,
        OP_LO32,
        OP_JMP,
        OP_FULL64
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic [ADDR_W-1:0]   addr;
        logic [VALUE_W-1:0]  operand;
        logic [WSIZE_W-1:0]  wsize;
        logic [STATUS_W-1:0] status;
    } cmd_t;

endpackage

@@ src/pebr_front.sv @@
// Front end: accepts entries, decodes type, tracks the pending HIGHADJ.
module pebr_front
    import pebr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tlast,
    input  logic                 q_full,
    output logic                 q_push,
    output cmd_t                 q_cmd
);

    logic                 adjust_pending_reg, adjust_pending_next;
    logic [HALF_W-1:0]    pending_high_reg, pending_high_next;
    logic [ADDR_W-1:0]    pending_addr_reg, pending_addr_next;

    logic [ENTRY_W-1:0]   entry;
    logic [ADDR_W-1:0]    page;
    logic [VALUE_W-1:0]   tval;
    logic [ADDR_W-1:0]    addr;
    logic [ADDR_W-1:0]    adj_base;

    assign entry = s_tdata[ENTRY_W-1:0];
    assign page  = s_tdata[ENTRY_W +: ADDR_W];
    assign tval  = s_tdata[ENTRY_W+ADDR_W +: VALUE_W];
    assign addr  = page + {{(ADDR_W-OFFSET_W){1'b0}}, entry[OFFSET_W-1:0]};

    // (H << 16) + sign-extended L + rounding
    assign adj_base = {pending_high_reg, {HALF_W{1'b0}}}
                    + {{(ADDR_W-ENTRY_W){entry[ENTRY_W-1]}}, entry}
                    + ROUND_HALF;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && s_tready;

    always_comb begin
        q_cmd.op      = OP_ZERO;
        q_cmd.addr    = addr;
        q_cmd.operand = '0;
        q_cmd.wsize   = WS_NONE;
        q_cmd.status  = ST_OK;
        adjust_pending_next = adjust_pending_reg;
        pending_high_next   = pending_high_reg;
        pending_addr_next   = pending_addr_reg;
        if (adjust_pending_reg) begin
            q_cmd.op      = OP_HI16;
            q_cmd.addr    = pending_addr_reg;
            q_cmd.operand = {{(VALUE_W-ADDR_W){1'b0}}, adj_base};
            q_cmd.wsize   = WS_16;
            adjust_pending_next = 1'b0;
        end else begin
            case (entry[ENTRY_W-1 -: 4])
                TY_ABSOLUTE: begin
                    q_cmd.op = OP_ZERO;
                end
                TY_HIGH: begin
                    q_cmd.op      = OP_HI16;
                    q_cmd.operand = {{(VALUE_W-ADDR_W){1'b0}}, tval[HALF_W-1:0],
                                     {HALF_W{1'b0}}};
                    q_cmd.wsize   = WS_16;
                end
                TY_LOW: begin
                    q_cmd.op      = OP_LO16;
                    q_cmd.operand = {{(VALUE_W-HALF_W){1'b0}}, tval[HALF_W-1:0]};
                    q_cmd.wsize   = WS_16;
                end
                TY_HIGHLOW: begin
                    q_cmd.op      = OP_LO32;
                    q_cmd.operand = {{(VALUE_W-ADDR_W){1'b0}}, tval[ADDR_W-1:0]};
                    q_cmd.wsize   = WS_32;
                end
                TY_HIGHADJ: begin
                    if (s_tlast) begin
                        q_cmd.status = ST_ADJ_MISSING;
                    end else begin
                        q_cmd.status        = ST_WAIT;
                        adjust_pending_next = 1'b1;
                        pending_high_next   = tval[HALF_W-1:0];
                        pending_addr_next   = addr;
                    end
                end
                TY_MIPS_JMPADDR: begin
                    // upper word carries bits 31..26, low word the field << 2
                    q_cmd.op      = OP_JMP;
                    q_cmd.operand = {26'b0, tval[31:26], 4'b0, tval[25:0], 2'b00};
                    q_cmd.wsize   = WS_32;
                end
                TY_DIR64: begin
                    q_cmd.op      = OP_FULL64;
                    q_cmd.operand = tval;
                    q_cmd.wsize   = WS_64;
                end
                default: begin
                    q_cmd.status = ST_UNSUPPORTED;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            adjust_pending_reg <= 1'b0;
        end else if (q_push) begin
            adjust_pending_reg <= adjust_pending_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_high_reg <= '0;
            pending_addr_reg <= '0;
        end else if (q_push) begin
            pending_high_reg <= pending_high_next;
            pending_addr_reg <= pending_addr_next;
        end
    end

endmodule

@@ src/pebr_queue.sv @@
// Small command queue between front and back end.
module pebr_queue
    import pebr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic valid,
    output cmd_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign valid = (count_reg != '0);
    assign head  = slots[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ src/pebr_back.sv @@
// Back end: holds base_delta, does the one 64-bit add and drives the output register.
module pebr_back
    import pebr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    input  logic [DELTA_W-1:0]   cfg_data,
    input  logic                 q_valid,
    input  cmd_t                 q_head,
    output logic                 q_pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic [DELTA_W-1:0]   delta_reg;
    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic [VALUE_W-1:0]   sum;
    logic [VALUE_W-1:0]   value;

    assign sum = q_head.operand + {{(VALUE_W-DELTA_W){1'b0}}, delta_reg};

    always_comb begin
        case (q_head.op)
            OP_HI16:   value = {{(VALUE_W-HALF_W){1'b0}}, sum[ADDR_W-1:HALF_W]};
            OP_LO16:   value = {{(VALUE_W-HALF_W){1'b0}}, sum[HALF_W-1:0]};
            OP_LO32:   value = {{(VALUE_W-ADDR_W){1'b0}}, sum[ADDR_W-1:0]};
            OP_JMP:    value = {{(VALUE_W-ADDR_W){1'b0}}, q_head.operand[37:32], sum[27:2]};
            OP_FULL64: value = sum;
            default:   value = '0;
        endcase
    end

    assign q_pop    = q_valid && (!m_valid_reg || m_tready);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delta_reg <= '0;
        end else if (cfg_valid) begin
            delta_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (q_pop) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            m_data_reg <= {{(M_TDATA_W-M_FIELD_W){1'b0}}, q_head.status, q_head.wsize,
                           value, q_head.addr};
        end
    end

endmodule

@@ src/pe_base_relocation_fixup.sv @@
// Top level of the base relocation fixup block.
// Applies PE/COFF base relocations one entry per request.
// Input stream (s_*): one relocation entry with its page address and the
// current target contents; s_tlast marks the final entry of a block.
// Output stream (m_*): target address, fixed-up value, write size, status.
// Config channel (cfg_*): writes base_delta; always ready, write only when idle.
// Throughput: one entry per cycle sustained while m_tready stays high. An
// accepted entry goes from the front decode into the queue, then through the
// back end's 64-bit add into the output register that drives m_tvalid.
// HIGHADJ gives a status-only result; if not last, the next entry completes it.
// When m_tready is low the output register holds, the queue fills, and
// s_tready drops once the queue (DEPTH entries) is full.
// Reset clears the queue, the output valid, the pending HIGHADJ and base_delta.
module pe_base_relocation_fixup
    import pebr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [DELTA_W-1:0]   cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [15:0] entry, [47:16] page_address, [111:48] target_value
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tlast,   // last_in_block
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [31:0] target_address, [95:32] new_value, [97:96] write_size,
    // [99:98] status, [103:100] zero
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic q_push, q_full, q_pop, q_valid;
    cmd_t push_cmd, head_cmd;

    assign cfg_ready = 1'b1;

    pebr_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    pebr_queue #(.DEPTH(DEPTH)) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .head     (head_cmd)
    );

    pebr_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_head    (head_cmd),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

@@ src/pebr_checker.sv @@
// Port-level checks for the base relocation fixup block, with its bind.
module pebr_checker
    import pebr_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    logic [WSIZE_W-1:0]  out_wsize;
    logic [STATUS_W-1:0] out_status;
    logic [VALUE_W-1:0]  out_value;

    assign out_wsize  = m_tdata[M_WSIZE_LSB +: WSIZE_W];
    assign out_status = m_tdata[M_STATUS_LSB +: STATUS_W];
    assign out_value  = m_tdata[M_VALUE_LSB +: VALUE_W];

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("stalled request dropped");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("stalled request changed");

    a_no_write_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (out_wsize == WS_NONE) |-> (out_value == '0))
        else $error("value nonzero without write");

    a_status_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (out_status != ST_OK) |-> (out_wsize == WS_NONE))
        else $error("write with non-ok status");

endmodule

bind pe_base_relocation_fixup pebr_checker u_pebr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
